FILE: rtl/firt_pkg.sv
// Shared types, constants and arithmetic helpers for the transposed FIR filter.
`default_nettype none

package firt_pkg;

  localparam int TAPS         = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ACC_WIDTH    = 40;
  localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
  localparam int TAP_IDX_W    = 4;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int NACT_W       = $clog2(TAPS + 1);
  localparam int ROW_IDX_W    = $clog2(TAPS);

  localparam logic [CFG_W-1:0] TAP_COUNT_RST    = CFG_W'(16);
  localparam logic [CFG_W-1:0] OUTPUT_SHIFT_RST = CFG_W'(15);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic [NACT_W-1:0]              nact_t;

  typedef enum logic [0:0] {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT    = 1'b0,
    REG_OUTPUT_SHIFT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    opcode_t                opcode;
    sample_t                sample_in;
    logic [TAP_IDX_W-1:0]   tap_index;
    sample_t                coef_value;
  } in_item_t;

  // control from the pipeline to the partial-sum row
  typedef struct packed {
    logic  en;
    nact_t n_act;
  } psum_ctrl_t;

  // zero taps act as one, anything above the row length clamps to it
  function automatic nact_t active_taps(input logic [CFG_W-1:0] tc);
    nact_t n;
    if (tc == '0) begin
      n = nact_t'(1);
    end else if (int'(tc) > TAPS) begin
      n = nact_t'(TAPS);
    end else begin
      n = nact_t'(tc);
    end
    return n;
  endfunction

  // arithmetic right shift, then clamp to the signed sample range
  function automatic sample_t shift_sat(input acc_t v, input logic [CFG_W-1:0] sh);
    acc_t s;
    acc_t hi;
    acc_t lo;
    sample_t r;
    s  = v >>> sh;
    hi = acc_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (s > hi) begin
      r = sample_t'(hi);
    end else if (s < lo) begin
      r = sample_t'(lo);
    end else begin
      r = s[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/firt_ifs.sv
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none

interface firt_in_if;
  import firt_pkg::*;
  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  sample_t              sample_in;
  logic [TAP_IDX_W-1:0] tap_index;
  sample_t              coef_value;
  modport source(output valid, opcode, sample_in, tap_index, coef_value, input ready);
  modport sink(input valid, opcode, sample_in, tap_index, coef_value, output ready);
endinterface

interface firt_out_if;
  import firt_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

interface firt_cfg_if;
  import firt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/firt_coef_mult.sv
// Coefficient store and one registered multiplier lane per tap.
`default_nettype none

module firt_coef_mult (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           load_en,
  input  wire logic [firt_pkg::TAP_IDX_W-1:0] load_idx,
  input  wire firt_pkg::sample_t              load_val,
  input  wire logic                           mul_en,
  input  wire firt_pkg::sample_t              sample,
  output firt_pkg::prod_t [firt_pkg::TAPS-1:0] prod_r
);
  import firt_pkg::*;

  sample_t [TAPS-1:0] coef_r;
  sample_t [TAPS-1:0] coef_nxt;
  prod_t   [TAPS-1:0] prod_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (load_en) begin
      for (int i = 0; i < TAPS; i++) begin
        if (int'(load_idx) == i) begin
          coef_nxt[i] = load_val;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod_nxt[i] = prod_t'(sample) * prod_t'(coef_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/firt_psum_row.sv
// Row of partial sums: accumulate, emit the head and shift the active part.
`default_nettype none

module firt_psum_row (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire firt_pkg::psum_ctrl_t             ctrl,
  input  wire firt_pkg::prod_t [firt_pkg::TAPS-1:0] prod,
  output firt_pkg::acc_t                        head_sum
);
  import firt_pkg::*;

  acc_t [TAPS-1:0] ps_r;
  acc_t [TAPS-1:0] ps_nxt;
  acc_t [TAPS-1:0] acc_sum;
  logic [ROW_IDX_W-1:0] last_idx;

  assign last_idx = ROW_IDX_W'(ctrl.n_act - nact_t'(1));

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      acc_sum[i] = ps_r[i] + acc_t'(prod[i]);
    end
  end

  assign head_sum = acc_sum[0];

  // position i takes i+1's new sum; the last active slot clears
  always_comb begin
    ps_nxt = ps_r;
    if (ctrl.en) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        if (i + 1 < int'(ctrl.n_act)) begin
          ps_nxt[i] = acc_sum[i+1];
        end else if (i + 1 == int'(ctrl.n_act)) begin
          ps_nxt[i] = '0;
        end
      end
      if (int'(ctrl.n_act) == TAPS) begin
        ps_nxt[TAPS-1] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= '0;
    end else begin
      ps_r <= ps_nxt;
    end
  end

  a_last_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.en |=> ps_r[$past(last_idx)] == '0)
    else $error("last active partial sum not cleared");

  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.en && int'(ctrl.n_act) < TAPS) |=> $stable(ps_r[TAPS-1]))
    else $error("inactive partial sum changed");

endmodule

`default_nettype wire

FILE: rtl/fir_filter_transposed_unit.sv
// Top level of the transposed-form FIR filter.
//
// Channels: in_if carries one transaction per item. opcode OP_FILTER feeds
// sample_in through the filter and yields one sample_out transaction on
// out_if; OP_LOAD writes coef_value to tap tap_index and yields nothing.
// cfg_if writes tap_count (index 0) and output_shift (index 1); it is
// always ready and is meant to be written while the filter is idle.
// Pipeline: input register -> per-tap multipliers into a product register
// -> partial-sum row update plus shift/saturate into the output register.
// Throughput: one item per cycle unless out_if stalls; all taps multiply
// and accumulate in parallel, so the partial-sum row update sets the rate.
// Each stage moves on its own, so a stalled out_if still lets bubbles and
// coefficient loads drain; in_if.ready drops only when the input register
// holds an item that cannot move on.
// Reset (rst_n low, synchronous): coefficients and partial sums clear to
// zero, tap_count goes to 16, output_shift to 15, all stages empty.
`default_nettype none

module fir_filter_transposed_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  firt_in_if.sink    in_if,
  firt_out_if.source out_if,
  firt_cfg_if.sink   cfg_if
);
  import firt_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] tap_count_r, tap_count_nxt;
  logic [CFG_W-1:0] shift_r, shift_nxt;

  // input register stage
  in_item_t in_r, in_nxt;
  logic     s1_v_r, s1_v_nxt;
  // product register stage (samples only)
  logic     s2_v_r, s2_v_nxt;
  // output register
  logic     out_v_r, out_v_nxt;
  sample_t  out_data_r, out_data_nxt;

  logic in_acc;
  logic out_free;
  logic s2_ready, s2_go;
  logic s1_go;
  logic mul_en, load_en;

  prod_t [TAPS-1:0] prod;
  acc_t             head_sum;
  psum_ctrl_t       psum_ctrl;

  // ---- stage control ----
  assign out_free = !out_v_r || out_if.ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_ready = !s2_v_r || out_free;
  // loads finish in the coefficient store and never need the product stage
  assign s1_go    = s1_v_r && ((in_r.opcode == OP_LOAD) || s2_ready);
  assign in_if.ready = !s1_v_r || s1_go;
  assign in_acc   = in_if.valid && in_if.ready;

  assign mul_en  = s1_go && (in_r.opcode == OP_FILTER);
  assign load_en = s1_go && (in_r.opcode == OP_LOAD);

  always_comb begin
    in_nxt   = in_r;
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      in_nxt.opcode     = in_if.opcode;
      in_nxt.sample_in  = in_if.sample_in;
      in_nxt.tap_index  = in_if.tap_index;
      in_nxt.coef_value = in_if.coef_value;
      s1_v_nxt          = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (mul_en) begin
      s2_v_nxt = 1'b1;
    end else if (s2_go) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    if (s2_go) begin
      out_v_nxt    = 1'b1;
      out_data_nxt = shift_sat(head_sum, shift_r);
    end else if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // ---- configuration port ----
  assign cfg_if.ready = 1'b1;

  always_comb begin
    tap_count_nxt = tap_count_r;
    shift_nxt     = shift_r;
    if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_TAP_COUNT:    tap_count_nxt = cfg_if.data;
        REG_OUTPUT_SHIFT: shift_nxt     = cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // ---- datapath ----
  firt_coef_mult u_coef_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_en  (load_en),
    .load_idx (in_r.tap_index),
    .load_val (in_r.coef_value),
    .mul_en   (mul_en),
    .sample   (in_r.sample_in),
    .prod_r   (prod)
  );

  assign psum_ctrl.en    = s2_go;
  assign psum_ctrl.n_act = active_taps(tap_count_r);

  firt_psum_row u_psum_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (psum_ctrl),
    .prod     (prod),
    .head_sum (head_sum)
  );

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
      shift_r     <= OUTPUT_SHIFT_RST;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      tap_count_r <= tap_count_nxt;
      shift_r     <= shift_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_if.valid      = out_v_r;
  assign out_if.sample_out = out_data_r;

  // ---- checks ----
  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_v_r && in_r.opcode == OP_FILTER && s2_v_r && !out_free))
    else $error("input stalled without a blocked sample ahead");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_free) |=> (s2_v_r && $stable(prod)))
    else $error("stalled product stage lost its transaction");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go |=> out_v_r)
    else $error("consumed sample produced no result");

endmodule

`default_nettype wire
